/* sv/shell_sort_halving_gaps_unit_assert.svh */
// assertion macros for the shell sort unit
// no dependencies; taken in by the modules that carry checks
`ifndef SHELL_SORT_HALVING_GAPS_UNIT_ASSERT_SVH
`define SHELL_SORT_HALVING_GAPS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// condition implies consequence in the same cycle
`define SSORT_ASSERT_SAME(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("shell sort check failed");

// condition implies consequence in the next cycle
`define SSORT_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("shell sort check failed");

`else

`define SSORT_ASSERT_SAME(lbl, clk, rst, cond, cons)
`define SSORT_ASSERT_NEXT(lbl, clk, rst, cond, cons)

`endif

`endif

/* sv/ssort_pkg.sv */
// shared types and constants for the shell sort unit
// used by ssort_ctrl, ssort_dpath and shell_sort_halving_gaps_unit
package ssort_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_data_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_res;
      logic                     overflow;
   } rsp_data_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAP_FIRST,
      ST_GAP_CHECK,
      ST_I_CHECK,
      ST_KEY,
      ST_J_CHECK,
      ST_CMP,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   typedef enum logic [1:0] {
      RD_I,
      RD_J_GAP,
      RD_K
   } rd_sel_type;

   typedef struct packed {
      logic       store;
      logic       gap_first;
      logic       gap_halve;
      logic       i_from_gap;
      logic       i_inc;
      logic       j_from_i;
      logic       j_dec;
      logic       key_load;
      rd_sel_type rd_sel;
      logic       wr_key;
      logic       wr_shift;
      logic       k_clear;
      logic       k_inc;
      logic       emit;
      logic       set_done;
   } cmd_type;

   typedef struct packed {
      logic gap_zero;
      logic i_done;
      logic j_ge_gap;
      logic greater;
      logic k_last;
   } status_type;

endpackage

/* sv/ssort_ctrl.sv */
// controller state machine for the shell sort unit
// depends on ssort_pkg; drives the command struct into ssort_dpath
module ssort_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_last,
   input  ssort_pkg::status_type status,
   output ssort_pkg::cmd_type    cmd,
   output logic                 busy
);

   ssort_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssort_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = ssort_pkg::RD_K;
      busy       = 1'b1;
      unique case (state_ff)
         ssort_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.store = 1'b1;
               if (req_last) begin
                  state_in = ssort_pkg::ST_GAP_FIRST;
               end
            end
         end
         ssort_pkg::ST_GAP_FIRST: begin
            cmd.gap_first = 1'b1;
            state_in      = ssort_pkg::ST_GAP_CHECK;
         end
         ssort_pkg::ST_GAP_CHECK: begin
            if (status.gap_zero) begin
               cmd.k_clear = 1'b1;
               state_in    = ssort_pkg::ST_EMIT_RD;
            end else begin
               cmd.i_from_gap = 1'b1;
               state_in       = ssort_pkg::ST_I_CHECK;
            end
         end
         ssort_pkg::ST_I_CHECK: begin
            if (status.i_done) begin
               cmd.gap_halve = 1'b1;
               state_in      = ssort_pkg::ST_GAP_CHECK;
            end else begin
               cmd.rd_sel   = ssort_pkg::RD_I;
               cmd.j_from_i = 1'b1;
               state_in     = ssort_pkg::ST_KEY;
            end
         end
         ssort_pkg::ST_KEY: begin
            cmd.key_load = 1'b1;
            state_in     = ssort_pkg::ST_J_CHECK;
         end
         ssort_pkg::ST_J_CHECK: begin
            if (status.j_ge_gap) begin
               cmd.rd_sel = ssort_pkg::RD_J_GAP;
               state_in   = ssort_pkg::ST_CMP;
            end else begin
               cmd.wr_key = 1'b1;
               cmd.i_inc  = 1'b1;
               state_in   = ssort_pkg::ST_I_CHECK;
            end
         end
         ssort_pkg::ST_CMP: begin
            // shift the larger neighbour up, or drop the key into its hole
            if (status.greater) begin
               cmd.wr_shift = 1'b1;
               cmd.j_dec    = 1'b1;
               state_in     = ssort_pkg::ST_J_CHECK;
            end else begin
               cmd.wr_key = 1'b1;
               cmd.i_inc  = 1'b1;
               state_in   = ssort_pkg::ST_I_CHECK;
            end
         end
         ssort_pkg::ST_EMIT_RD: begin
            cmd.rd_sel = ssort_pkg::RD_K;
            state_in   = ssort_pkg::ST_EMIT_OUT;
         end
         ssort_pkg::ST_EMIT_OUT: begin
            cmd.emit = 1'b1;
            if (status.k_last) begin
               cmd.set_done = 1'b1;
               state_in     = ssort_pkg::ST_IDLE;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = ssort_pkg::ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ssort_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/ssort_dpath.sv */
// datapath for the shell sort unit: element memory, indices, key and compare
// depends on ssort_pkg and shell_sort_halving_gaps_unit_assert.svh
`include "shell_sort_halving_gaps_unit_assert.svh"

module ssort_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  ssort_pkg::cmd_type      cmd,
   input  ssort_pkg::req_data_type req_data,
   output ssort_pkg::status_type   status,
   output logic                   rsp_valid,
   output ssort_pkg::rsp_data_type rsp_data
);

   localparam int AW = ssort_pkg::ADDR_W;
   localparam int CW = ssort_pkg::CNT_W;
   localparam int DW = ssort_pkg::DATA_W;

   logic signed [DW-1:0] mem [ssort_pkg::DEPTH];

   logic [CW-1:0]        count_ff, count_in;
   logic                 drop_ff, drop_in;
   logic [AW-1:0]        gap_ff, gap_in;
   logic [CW-1:0]        i_ff, i_in;
   logic [AW-1:0]        j_ff, j_in;
   logic [AW-1:0]        k_ff, k_in;
   logic signed [DW-1:0] key_ff, key_in;
   logic signed [DW-1:0] rd_data_ff;

   logic                 has_room;
   logic [AW-1:0]        j_minus_gap;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic signed [DW-1:0] wr_data;

   assign has_room    = count_ff < CW'(ssort_pkg::DEPTH);
   assign j_minus_gap = j_ff - gap_ff;

   always_comb begin
      case (cmd.rd_sel)
         ssort_pkg::RD_I:     rd_addr = i_ff[AW-1:0];
         ssort_pkg::RD_J_GAP: rd_addr = j_minus_gap;
         default:             rd_addr = k_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = j_ff;
      wr_data = key_ff;
      if (cmd.store) begin
         wr_en   = has_room;
         wr_addr = count_ff[AW-1:0];
         wr_data = req_data.value;
      end else if (cmd.wr_shift) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff;
      end else if (cmd.wr_key) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      if (cmd.set_done) begin
         count_in = '0;
         drop_in  = 1'b0;
      end else if (cmd.store) begin
         if (has_room) begin
            count_in = count_ff + CW'(1);
         end else begin
            drop_in = 1'b1;
         end
      end
   end

   always_comb begin
      gap_in = gap_ff;
      i_in   = i_ff;
      j_in   = j_ff;
      k_in   = k_ff;
      key_in = key_ff;
      if (cmd.gap_first) gap_in = AW'(count_ff >> 1);
      if (cmd.gap_halve) gap_in = gap_ff >> 1;
      if (cmd.i_from_gap) i_in = CW'(gap_ff);
      if (cmd.i_inc) i_in = i_ff + CW'(1);
      if (cmd.j_from_i) j_in = i_ff[AW-1:0];
      if (cmd.j_dec) j_in = j_minus_gap;
      if (cmd.k_clear) k_in = '0;
      if (cmd.k_inc) k_in = k_ff + AW'(1);
      if (cmd.key_load) key_in = rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff <= gap_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      key_ff <= key_in;
   end

   assign status.gap_zero = gap_ff == '0;
   assign status.i_done   = i_ff >= count_ff;
   assign status.j_ge_gap = j_ff >= gap_ff;
   assign status.greater  = rd_data_ff > key_ff;
   assign status.k_last   = (CW'(k_ff) + CW'(1)) == count_ff;

   assign rsp_valid             = cmd.emit;
   assign rsp_data.sorted_value = rd_data_ff;
   assign rsp_data.last_res     = status.k_last;
   assign rsp_data.overflow     = drop_ff;

   `SSORT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(ssort_pkg::DEPTH))
   `SSORT_ASSERT_SAME(a_drop_full, clock, reset, drop_ff, count_ff == CW'(ssort_pkg::DEPTH))
   `SSORT_ASSERT_SAME(a_sort_wr_in_set, clock, reset, cmd.wr_key || cmd.wr_shift,
                      CW'(j_ff) < count_ff)
   `SSORT_ASSERT_SAME(a_emit_in_set, clock, reset, cmd.emit, CW'(k_ff) < count_ff)
   `SSORT_ASSERT_NEXT(a_done_clears, clock, reset, cmd.set_done, count_ff == '0 && !drop_ff)

endmodule

/* sv/shell_sort_halving_gaps_unit.sv */
// Shell sort unit, halving gaps. Signed 32-bit elements load one per cycle
// (start high while busy low); the element flagged last closes the set and
// busy rises. Elements past DEPTH are dropped and flagged as overflow. The
// sort runs on one single-port-read, single-port-write memory: each gap pass
// is a gapped insertion over every element, moving larger neighbours up by
// the gap; the first gap is half the set size and each pass halves it.
// Results then come out in ascending order, each for exactly one cycle on
// rsp_valid; the receiver cannot stall them, so it must take every strobe.
// Depends on ssort_pkg, ssort_ctrl and ssort_dpath.
module shell_sort_halving_gaps_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ssort_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   output ssort_pkg::rsp_data_type rsp_data
);

   ssort_pkg::cmd_type    cmd;
   ssort_pkg::status_type status;

   ssort_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_data.last),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   ssort_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/shell_sort_halving_gaps_unit_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for shell_sort_halving_gaps_unit: directed table, then random sets
// depends on ssort_pkg and the shell sort unit; predicts each sorted set and checks every strobe
module shell_sort_halving_gaps_unit_test;

   typedef struct packed {
      ssort_pkg::req_data_type item;
      bit                      typed;
      ssort_pkg::rsp_data_type typed_rsp;
   } stim_row_type;

   localparam int NUM_ROWS = 22;
   localparam int RANDOM_ITEMS = 188;

   // single-element sets carry their result typed in; the rest go through the predictor
   localparam stim_row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      '{'{32'sh7FFFFFFF, 1'b1}, 1'b1, '{32'sh7FFFFFFF, 1'b1, 1'b0}},
      '{'{32'sh80000000, 1'b1}, 1'b1, '{32'sh80000000, 1'b1, 1'b0}},
      '{'{32'sh00000000, 1'b1}, 1'b1, '{32'sh00000000, 1'b1, 1'b0}},
      '{'{32'shFFFFFFFF, 1'b1}, 1'b1, '{32'shFFFFFFFF, 1'b1, 1'b0}},
      '{'{32'sh00000005, 1'b0}, 1'b0, '0},
      '{'{32'shFFFFFFFF, 1'b0}, 1'b0, '0},
      '{'{32'sh80000000, 1'b0}, 1'b0, '0},
      '{'{32'sh7FFFFFFF, 1'b0}, 1'b0, '0},
      '{'{32'sh00000000, 1'b1}, 1'b0, '0},
      '{'{32'sh00000007, 1'b0}, 1'b0, '0},
      '{'{32'shFFFFFFF9, 1'b1}, 1'b0, '0},
      '{'{32'sh00000003, 1'b0}, 1'b0, '0},
      '{'{32'sh00000003, 1'b0}, 1'b0, '0},
      '{'{32'shFFFFFFFD, 1'b0}, 1'b0, '0},
      '{'{32'sh00000003, 1'b0}, 1'b0, '0},
      '{'{32'sh80000000, 1'b0}, 1'b0, '0},
      '{'{32'sh80000000, 1'b1}, 1'b0, '0},
      '{'{32'shFFFFFFFE, 1'b0}, 1'b0, '0},
      '{'{32'shFFFFFFFF, 1'b0}, 1'b0, '0},
      '{'{32'sh00000000, 1'b0}, 1'b0, '0},
      '{'{32'sh00000001, 1'b0}, 1'b0, '0},
      '{'{32'sh00000002, 1'b1}, 1'b0, '0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   ssort_pkg::req_data_type req_data = '0;
   logic                    rsp_valid;
   ssort_pkg::rsp_data_type rsp_data;

   logic signed [ssort_pkg::DATA_W-1:0] held_values [0:ssort_pkg::DEPTH-1];
   int                      held_count = 0;
   bit                      elements_lost = 1'b0;
   ssort_pkg::rsp_data_type sorted_due [$];
   int                      mismatch_count = 0;
   int                      burst_left = 0;

   shell_sort_halving_gaps_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // store one element; a closing element sorts the set with halving gaps
   task automatic take_element(input ssort_pkg::req_data_type item, input bit record);
      logic signed [ssort_pkg::DATA_W-1:0] key;
      ssort_pkg::rsp_data_type             sorted_rsp;
      int                                  j;
      if (held_count < ssort_pkg::DEPTH) begin
         held_values[held_count] = item.value;
         held_count++;
      end else begin
         elements_lost = 1'b1;
      end
      if (item.last) begin
         for (int gap = held_count / 2; gap > 0; gap /= 2) begin
            for (int c = 0; c < gap; c++) begin
               for (int i = c + gap; i < held_count; i += gap) begin
                  key = held_values[i];
                  j = i;
                  while (j >= gap && held_values[j-gap] > key) begin
                     held_values[j] = held_values[j-gap];
                     j -= gap;
                  end
                  held_values[j] = key;
               end
            end
         end
         if (record) begin
            for (int k = 0; k < held_count; k++) begin
               sorted_rsp.sorted_value = held_values[k];
               sorted_rsp.last_res     = (k == held_count - 1);
               sorted_rsp.overflow     = elements_lost;
               sorted_due.push_back(sorted_rsp);
            end
         end
         held_count = 0;
         elements_lost = 1'b0;
      end
   endtask

   // bursts of transfers with idle gaps between them, then wait for the transfer
   task automatic send_element(input ssort_pkg::req_data_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_data <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   always @(posedge clock) begin
      ssort_pkg::rsp_data_type due;
      if (!reset && rsp_valid) begin
         if (sorted_due.size() == 0) begin
            $error("unexpected result: sorted_value %0d", rsp_data.sorted_value);
            mismatch_count++;
         end else begin
            due = sorted_due.pop_front();
            if (rsp_data.sorted_value !== due.sorted_value) begin
               $error("sorted_value: expected %0d, got %0d",
                      due.sorted_value, rsp_data.sorted_value);
               mismatch_count++;
            end
            if (rsp_data.last_res !== due.last_res) begin
               $error("last_res: expected %0b, got %0b", due.last_res, rsp_data.last_res);
               mismatch_count++;
            end
            if (rsp_data.overflow !== due.overflow) begin
               $error("overflow: expected %0b, got %0b", due.overflow, rsp_data.overflow);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      ssort_pkg::req_data_type item;
      int                      random_items;
      int                      set_len;
      int                      set_index;
      random_items = 0;
      set_index = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         send_element(DIRECTED_ROWS[r].item);
         if (DIRECTED_ROWS[r].typed) begin
            sorted_due.push_back(DIRECTED_ROWS[r].typed_rsp);
         end
         take_element(DIRECTED_ROWS[r].item, !DIRECTED_ROWS[r].typed);
      end

      // first a set whose closing element is dropped, then an exactly full one
      while (random_items < RANDOM_ITEMS) begin
         case (set_index)
            0: set_len = ssort_pkg::DEPTH + 1;
            1: set_len = ssort_pkg::DEPTH;
            default: begin
               case ($urandom_range(0, 15))
                  0:       set_len = ssort_pkg::DEPTH;
                  1:       set_len = $urandom_range(ssort_pkg::DEPTH + 1,
                                                    ssort_pkg::DEPTH + 8);
                  default: set_len = $urandom_range(1, 12);
               endcase
            end
         endcase
         set_index++;
         for (int e = 0; e < set_len; e++) begin
            case ($urandom_range(0, 7))
               0: begin
                  case ($urandom_range(0, 3))
                     0:       item.value = 32'sh7FFFFFFF;
                     1:       item.value = 32'sh80000000;
                     2:       item.value = 32'sh00000000;
                     default: item.value = 32'shFFFFFFFF;
                  endcase
               end
               // narrow range so that duplicates turn up
               1:       item.value = $signed($urandom_range(0, 15)) - 8;
               default: item.value = $urandom;
            endcase
            item.last = (e == set_len - 1);
            send_element(item);
            take_element(item, 1'b1);
            random_items++;
         end
      end
      start <= 1'b0;

      while (sorted_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && sorted_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/ssort_pkg.sv
sv/ssort_ctrl.sv
sv/ssort_dpath.sv
sv/shell_sort_halving_gaps_unit.sv
tb/shell_sort_halving_gaps_unit_test.sv
